// ----- rtl/fmpc_pkg.sv -----
`default_nettype none
package fmpc_pkg;
	localparam int MAX_CHANNELS = 512;
	localparam int LANES = 8;
	localparam int GROUPS = MAX_CHANNELS / LANES;
	localparam int GW = $clog2(GROUPS);
	localparam int CW = $clog2(MAX_CHANNELS + 1);
	localparam int LW = $clog2(LANES + 1);
	localparam logic [15:0] QNAN16 = 16'h7E00;

	typedef enum logic [1:0] {
		REG_KERNEL = 2'd0,
		REG_CHANNELS = 2'd1,
		REG_CLAMP_LO = 2'd2,
		REG_CLAMP_HI = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic first;
		logic last_elem;
		logic last_group;
		logic [LW-1:0] valid;
	} step_ctl_t;

	function automatic logic h_is_nan(input logic [15:0] b);
		h_is_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
	endfunction

	function automatic logic [15:0] h_key(input logic [15:0] b);
		h_key = b[15] ? ~b : (b | 16'h8000);
	endfunction

	function automatic logic [15:0] h_max(input logic [15:0] a, input logic [15:0] b);
		if (h_is_nan(a) || h_is_nan(b)) h_max = QNAN16;
		else h_max = (h_key(a) >= h_key(b)) ? a : b;
	endfunction

	function automatic logic [15:0] h_min(input logic [15:0] a, input logic [15:0] b);
		if (h_is_nan(a) || h_is_nan(b)) h_min = QNAN16;
		else h_min = (h_key(a) <= h_key(b)) ? a : b;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/fmpc_lane.sv -----
`default_nettype none
// One lane: running max memory over channel groups, then clamp.
// Read is registered at accept; the write of the beat leaving s1 is forwarded
// when the incoming beat reads the same group.
module fmpc_lane (
	input wire logic clk,
	input wire logic acc,
	input wire logic [fmpc_pkg::GW-1:0] grp,
	input wire logic [15:0] din,
	input wire logic adv,
	input wire logic first_s1,
	input wire logic use_s1,
	input wire logic [fmpc_pkg::GW-1:0] grp_s1,
	input wire logic [15:0] lo,
	input wire logic [15:0] hi,
	output logic [15:0] dout
);
	import fmpc_pkg::*;
	logic [15:0] mem [GROUPS];
	logic [15:0] din_s1;
	logic [15:0] rd_raw_s1;
	logic [15:0] fwd_val_s1;
	logic fwd_s1;
	logic [15:0] rd;
	logic [15:0] m;
	logic wr;

	assign wr = adv && use_s1;
	assign rd = fwd_s1 ? fwd_val_s1 : rd_raw_s1;
	assign m = first_s1 ? din_s1 : h_max(rd, din_s1);
	assign dout = use_s1 ? h_max(h_min(m, hi), lo) : 16'd0;

	always_ff @(posedge clk) begin
		if (wr) mem[grp_s1] <= m;
		if (acc) begin
			din_s1 <= din;
			rd_raw_s1 <= mem[grp];
			fwd_s1 <= wr && (grp_s1 == grp);
			fwd_val_s1 <= m;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/fp16_max_pool_clamp_top.sv -----
`default_nettype none
// fp16 max pooling with output clamp, 8 lanes.
// s_axis: one channel group per beat, tdata = lane0..lane7 (lane0 lowest).
// cfg: index 0 kernel_size, 1 channel_count, 2 clamp_low, 3 clamp_high.
//   Writing kernel_size or channel_count restarts the pixel. cfg_ready is high
//   only with s1 and the output register empty; s_axis_tready is low while
//   cfg_valid is high.
// m_axis: one beat per group on the last window element; tdata = out_lane0..7,
//   tuser = {pixel_done, valid_lanes} (valid_lanes lowest).
// Throughput: one beat per cycle while cfg_valid is low and the output register
//   is not stalled; each lane does one compare per beat against its per-group running max.
// Path: the running max read for an accepted beat is registered in s1; compare and
//   clamp feed the output register, which drives m_axis_tvalid.
// Reset clears counters and the pipeline and sets registers to defaults;
//   running max holds junk until the first window element writes it.
// Receiver stall: the output register holds; s_axis_tready drops only when s1 holds a
//   last-element beat and the output register is full and not drained, or on cfg_valid.
module fp16_max_pool_clamp_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [127:0] s_axis_tdata, // lane0_value..lane7_value
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [127:0] m_axis_tdata, // out_lane0..out_lane7
	output logic [7:0] m_axis_tuser, // valid_lanes[3:0], pixel_done[4], zero
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import fmpc_pkg::*;
	logic [7:0] kern_q;
	logic [9:0] chan_q;
	logic [15:0] lo_q, hi_q;
	logic [7:0] elem_q;
	logic [GW-1:0] grp_q;
	logic [CW-1:0] ch_eff;
	logic [7:0] k_eff;
	logic [GW:0] ngrp;
	step_ctl_t ctl;
	step_ctl_t ctl_s1;
	logic [GW-1:0] grp_s1;
	logic valid_s1;
	logic adv;
	logic acc;
	logic [15:0] lane_out [LANES];
	logic [LW-1:0] vfull;

	assign cfg_ready = !valid_s1 && !m_axis_tvalid;
	assign ch_eff = (chan_q == 10'd0) ? CW'(1) :
		(chan_q > 10'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : CW'(chan_q);
	assign k_eff = (kern_q == 8'd0) ? 8'd1 : kern_q;
	assign ngrp = (GW+1)'((ch_eff + CW'(LANES - 1)) / LANES);
	assign vfull = LW'(LANES);

	always_comb begin
		logic [CW-1:0] rem;
		rem = ch_eff - CW'({grp_q, {$clog2(LANES){1'b0}}});
		ctl.first = (elem_q == 8'd0);
		ctl.last_elem = ({1'b0, elem_q} + 9'd1 >= {1'b0, k_eff});
		ctl.last_group = ({1'b0, grp_q} + (GW+1)'(1) >= ngrp);
		ctl.valid = (rem > CW'(LANES)) ? vfull : LW'(rem);
	end

	// s1 leaves unless it carries a result that cannot enter the output register
	assign adv = valid_s1 && (!ctl_s1.last_elem || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = (!valid_s1 || adv) && !cfg_valid;
	assign acc = s_axis_tvalid && s_axis_tready;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		fmpc_lane u_lane (
			.clk(clk), .acc(acc), .grp(grp_q), .din(s_axis_tdata[16*l +: 16]),
			.adv(adv), .first_s1(ctl_s1.first),
			.use_s1(LW'(l) < ctl_s1.valid), .grp_s1(grp_s1),
			.lo(lo_q), .hi(hi_q), .dout(lane_out[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q <= 8'd1;
			chan_q <= 10'd8;
			lo_q <= 16'hFC00;
			hi_q <= 16'h7C00;
			elem_q <= '0;
			grp_q <= '0;
			valid_s1 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			m_axis_tvalid <= (adv && ctl_s1.last_elem) || (m_axis_tvalid && !m_axis_tready);
			if (acc) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (reg_idx_t'(cfg_index))
					REG_KERNEL: begin
						kern_q <= cfg_data[7:0];
						elem_q <= '0;
						grp_q <= '0;
					end
					REG_CHANNELS: begin
						chan_q <= cfg_data[9:0];
						elem_q <= '0;
						grp_q <= '0;
					end
					REG_CLAMP_LO: lo_q <= cfg_data;
					REG_CLAMP_HI: hi_q <= cfg_data;
					default: ;
				endcase
			end else if (acc) begin
				if (ctl.last_group) begin
					grp_q <= '0;
					elem_q <= ctl.last_elem ? 8'd0 : elem_q + 8'd1;
				end else begin
					grp_q <= grp_q + GW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1 <= ctl;
			grp_s1 <= grp_q;
		end
		if (adv && ctl_s1.last_elem) begin
			for (int l = 0; l < LANES; l++) m_axis_tdata[16*l +: 16] <= lane_out[l];
			m_axis_tuser <= {3'd0, ctl_s1.last_group, ctl_s1.valid};
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.valid != '0 && ctl.valid <= vfull) else $error("bad lane count");
	a_grp_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, grp_q} < ngrp) else $error("group counter out of range");
endmodule
`default_nettype wire
